@@ rtl/skt_pkg.sv @@
`timescale 1ns / 1ps

package skt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int IDX_W       = 4;
    localparam int STATUS_W    = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ      = 3'd4;

    typedef struct packed {
        logic                    strobe;
        logic [STATUS_W-1:0]     status;
        logic [CNT_W-1:0]        count;
        logic signed [KEY_W-1:0] value;
        logic                    valid;
    } t_result;

endpackage

@@ rtl/skt_ram.sv @@
`timescale 1ns / 1ps

module skt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/skt_ctrl.sv @@
`timescale 1ns / 1ps

module skt_ctrl
    import skt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [OP_W-1:0]         i_operation,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [IDX_W-1:0]        i_index,
    output logic                    o_busy,
    output logic                    o_we,
    output logic [ADDR_W-1:0]       o_waddr,
    output logic [KEY_W-1:0]        o_wdata,
    output logic [ADDR_W-1:0]       o_raddr,
    input  logic [KEY_W-1:0]        i_rdata,
    output t_result                 o_result
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS     = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_DEL     = 3'd3;
    localparam logic [2:0] S_DEL_CMP = 3'd4;
    localparam logic [2:0] S_RD      = 3'd5;
    localparam logic [2:0] S_RD_WAIT = 3'd6;

    logic [2:0]              r_state, n_state;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_ptr, n_ptr;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_found, n_found;

    logic [CNT_W-1:0] w_ptr_dec;
    logic             w_key_lt;
    logic             w_key_eq;

    assign w_ptr_dec = r_ptr - 1'b1;
    assign w_key_lt  = r_key < $signed(i_rdata);
    assign w_key_eq  = r_key == $signed(i_rdata);
    assign o_busy    = r_state != S_IDLE;

    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_idx    = r_idx;
        n_ptr    = r_ptr;
        n_count  = r_count;
        n_found  = r_found;
        o_we     = 1'b0;
        o_waddr  = r_ptr[ADDR_W-1:0];
        o_wdata  = r_key;
        o_raddr  = r_ptr[ADDR_W-1:0];
        o_result = '0;
        o_result.count = r_count;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key   = i_key;
                    n_idx   = i_index;
                    n_ptr   = r_count;
                    n_found = 1'b0;
                    unique case (i_operation)
                        OP_INSERT: n_state = S_INS;
                        OP_DELETE: begin
                            n_state = S_DEL;
                            n_ptr   = '0;
                        end
                        default:   n_state = S_RD;
                    endcase
                end
            end
            S_INS: begin
                if (r_count == CNT_W'(TABLE_DEPTH)) begin
                    o_result.strobe = 1'b1;
                    o_result.status = ST_FULL;
                    n_state         = S_IDLE;
                end else if (r_ptr == '0) begin
                    o_we            = 1'b1;
                    n_count         = r_count + 1'b1;
                    o_result.strobe = 1'b1;
                    o_result.status = ST_INSERTED;
                    o_result.count  = n_count;
                    n_state         = S_IDLE;
                end else begin
                    o_raddr = w_ptr_dec[ADDR_W-1:0];
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_we = 1'b1;
                if (w_key_lt) begin
                    o_wdata = i_rdata;
                    n_ptr   = w_ptr_dec;
                    n_state = S_INS;
                end else begin
                    n_count         = r_count + 1'b1;
                    o_result.strobe = 1'b1;
                    o_result.status = ST_INSERTED;
                    o_result.count  = n_count;
                    n_state         = S_IDLE;
                end
            end
            S_DEL: begin
                if (r_ptr == r_count) begin
                    o_result.strobe = 1'b1;
                    if (r_found) begin
                        n_count         = r_count - 1'b1;
                        o_result.status = ST_DELETED;
                        o_result.count  = n_count;
                    end else begin
                        o_result.status = ST_NOT_FOUND;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DEL_CMP;
                end
            end
            S_DEL_CMP: begin
                if (r_found) begin
                    o_we    = 1'b1;
                    o_waddr = w_ptr_dec[ADDR_W-1:0];
                    o_wdata = i_rdata;
                end else if (w_key_eq) begin
                    n_found = 1'b1;
                end
                n_ptr   = r_ptr + 1'b1;
                n_state = S_DEL;
            end
            S_RD: begin
                o_raddr = r_idx[ADDR_W-1:0];
                if (CNT_W'(r_idx) < r_count) begin
                    n_state = S_RD_WAIT;
                end else begin
                    o_result.strobe = 1'b1;
                    o_result.status = ST_READ;
                    n_state         = S_IDLE;
                end
            end
            S_RD_WAIT: begin
                o_result.strobe = 1'b1;
                o_result.status = ST_READ;
                o_result.value  = $signed(i_rdata);
                o_result.valid  = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_key   <= n_key;
        r_idx   <= n_idx;
        r_ptr   <= n_ptr;
        r_found <= n_found;
    end

endmodule

@@ rtl/sorted_key_table.sv @@
// An insert moves each stored key greater than the new key up one place and is refused on a
// full table; a delete walks over every entry; a read looks up one entry by index.
// Throughput: one operation at a time; the next start is taken once busy falls.
// Reset clears the entry count and the sequencer; the key memory is not cleared.
// Each result beat is shown for one cycle on o_done; the receiver cannot stall.
`timescale 1ns / 1ps

module sorted_key_table
    import skt_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OP_W-1:0]            i_operation,
    input  logic signed [KEY_W-1:0]    i_key,
    input  logic [IDX_W-1:0]           i_index,
    output logic                       o_done,
    output logic [STATUS_W-1:0]        o_status,
    output logic [CNT_W-1:0]           o_entry_count,
    output logic signed [KEY_W-1:0]    o_read_value,
    output logic                       o_read_valid
);

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [KEY_W-1:0]  w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [KEY_W-1:0]  w_rdata;
    t_result           w_result;
    t_result           r_result;

    skt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_index     (i_index),
        .o_busy      (busy),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_result    (w_result)
    );

    skt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (KEY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result.strobe <= 1'b0;
        end else begin
            r_result.strobe <= w_result.strobe;
        end
        if (w_result.strobe) begin
            r_result.status <= w_result.status;
            r_result.count  <= w_result.count;
            r_result.value  <= w_result.value;
            r_result.valid  <= w_result.valid;
        end
    end

    assign o_done        = r_result.strobe;
    assign o_status      = r_result.status;
    assign o_entry_count = r_result.count;
    assign o_read_value  = r_result.value;
    assign o_read_valid  = r_result.valid;

endmodule

@@ bench/key_table_checker.sv @@
`timescale 1ns / 1ps

// Watches the command and result ports, keeps its own copy of the sorted table and
// compares every result beat with the oldest outstanding prediction.
module key_table_checker
    import skt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [OP_W-1:0]         i_operation,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [IDX_W-1:0]        i_index,
    input  logic                    i_done,
    input  logic [STATUS_W-1:0]     i_status,
    input  logic [CNT_W-1:0]        i_entry_count,
    input  logic signed [KEY_W-1:0] i_read_value,
    input  logic                    i_read_valid,
    output int                      o_mismatches,
    output int                      o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [CNT_W-1:0]        count;
        logic signed [KEY_W-1:0] value;
        logic                    valid;
    } t_outcome;

    logic signed [KEY_W-1:0] table_keys [TABLE_DEPTH];
    int unsigned             table_count;
    t_outcome                outcome_queue [$];
    t_outcome                due;
    t_outcome                fresh;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        table_count  = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $time, what);
        o_mismatches++;
    endtask

    task automatic apply_operation(
        input  logic [OP_W-1:0]         op,
        input  logic signed [KEY_W-1:0] key,
        input  logic [IDX_W-1:0]        idx,
        output t_outcome                res
    );
        int unsigned pos;
        int unsigned k;
        res = '0;
        if (op == OP_INSERT) begin
            if (table_count >= TABLE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // Equal keys keep their arrival order: skip past them.
                pos = 0;
                while (pos < table_count && !(key < table_keys[pos])) pos++;
                for (k = table_count; k > pos; k--) table_keys[k] = table_keys[k-1];
                table_keys[pos] = key;
                table_count++;
                res.status = ST_INSERTED;
            end
        end else if (op == OP_DELETE) begin
            pos = 0;
            while (pos < table_count && table_keys[pos] != key) pos++;
            if (pos >= table_count) begin
                res.status = ST_NOT_FOUND;
            end else begin
                for (k = pos; k + 1 < table_count; k++) table_keys[k] = table_keys[k+1];
                table_count--;
                res.status = ST_DELETED;
            end
        end else begin
            res.status = ST_READ;
            if (idx < table_count) begin
                res.valid = 1'b1;
                res.value = table_keys[idx];
            end
        end
        res.count = CNT_W'(table_count);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            outcome_queue.delete();
            table_count = 0;
        end else begin
            // A result beat always belongs to an earlier command, so it is retired first.
            if (i_done) begin
                if (outcome_queue.size() == 0) begin
                    report_mismatch($sformatf("result beat with status %0d but none outstanding",
                                              i_status));
                end else begin
                    due = outcome_queue.pop_front();
                    if (i_status !== due.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, due.status));
                    if (i_entry_count !== due.count)
                        report_mismatch($sformatf("entry count %0d, expected %0d",
                                                  i_entry_count, due.count));
                    if (i_read_value !== due.value)
                        report_mismatch($sformatf("read value %0d, expected %0d",
                                                  i_read_value, due.value));
                    if (i_read_valid !== due.valid)
                        report_mismatch($sformatf("read valid %0b, expected %0b",
                                                  i_read_valid, due.valid));
                end
            end
            if (i_start && !i_busy) begin
                apply_operation(i_operation, i_key, i_index, fresh);
                outcome_queue.push_back(fresh);
            end
        end
        o_pending = outcome_queue.size();
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench
    import skt_pkg::*;
();

    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 60;
    localparam int PHASE_ITEMS  = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 12;

    localparam logic [OP_W-1:0]         OP_SPARE = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MAX  = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_MIN  = {1'b1, {(KEY_W-1){1'b0}}};

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    start         = 1'b0;
    logic                    busy;
    logic [OP_W-1:0]         i_operation   = OP_INSERT;
    logic signed [KEY_W-1:0] i_key         = '0;
    logic [IDX_W-1:0]        i_index       = '0;
    logic                    o_done;
    logic [STATUS_W-1:0]     o_status;
    logic [CNT_W-1:0]        o_entry_count;
    logic signed [KEY_W-1:0] o_read_value;
    logic                    o_read_valid;

    int                      mismatches;
    int                      pending;
    int unsigned             cycle_count   = 0;
    int                      insert_share  = 50;
    logic signed [KEY_W-1:0] key_pool [8];

    always #5 i_clk = ~i_clk;

    sorted_key_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_index       (i_index),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_read_value  (o_read_value),
        .o_read_valid  (o_read_valid)
    );

    key_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_index       (i_index),
        .i_done        (o_done),
        .i_status      (o_status),
        .i_entry_count (o_entry_count),
        .i_read_value  (o_read_value),
        .i_read_valid  (o_read_valid),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic issue(
        input logic [OP_W-1:0]         op,
        input logic signed [KEY_W-1:0] key,
        input logic [IDX_W-1:0]        idx
    );
        i_operation <= op;
        i_key       <= key;
        i_index     <= idx;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Keys come mostly from a small pool so that deletes hit and equal keys pile up.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return key_pool[$urandom_range(0, 7)];
        if (r < 75) return $urandom;
        if (r < 88) return KEY_W'($urandom_range(0, 20)) - KEY_W'(10);
        case ($urandom_range(0, 3))
            0: return KEY_MAX;
            1: return KEY_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    initial begin
        int               n;
        int               r;
        logic [OP_W-1:0]  op;
        foreach (key_pool[k]) key_pool[k] = $urandom;
        key_pool[0] = KEY_MAX;
        key_pool[1] = KEY_MIN;
        key_pool[2] = '0;
        key_pool[3] = '1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(OP_READ, $urandom, 4'd0);
        issue(OP_DELETE, 32'sd5, IDX_W'($urandom));
        issue(OP_INSERT, KEY_MAX, IDX_W'($urandom));
        issue(OP_INSERT, KEY_MIN, IDX_W'($urandom));
        issue(OP_INSERT, 32'sd0, IDX_W'($urandom));
        issue(OP_INSERT, 32'sd0, IDX_W'($urandom));
        issue(OP_INSERT, -32'sd1, IDX_W'($urandom));
        issue(OP_INSERT, 32'sd1, IDX_W'($urandom));
        issue(OP_INSERT, 32'sd100, IDX_W'($urandom));
        issue(OP_INSERT, -32'sd100, IDX_W'($urandom));
        issue(OP_INSERT, 32'sd0, IDX_W'($urandom));
        issue(OP_INSERT, 32'sd7, IDX_W'($urandom));
        issue(OP_INSERT, 32'sd7, IDX_W'($urandom));
        issue(OP_INSERT, 32'sh1234_5678, IDX_W'($urandom));
        issue(OP_INSERT, 32'shA5A5_A5A5, IDX_W'($urandom));
        issue(OP_INSERT, 32'sd42, IDX_W'($urandom));
        issue(OP_INSERT, -32'sd42, IDX_W'($urandom));
        issue(OP_INSERT, 32'sd3, IDX_W'($urandom));
        issue(OP_INSERT, 32'sd9, IDX_W'($urandom));
        issue(OP_READ, $urandom, 4'd15);
        issue(OP_SPARE, $urandom, 4'd0);
        issue(OP_DELETE, 32'sd0, IDX_W'($urandom));
        issue(OP_DELETE, 32'sd12345, IDX_W'($urandom));
        issue(OP_DELETE, KEY_MAX, IDX_W'($urandom));
        issue(OP_READ, $urandom, 4'd15);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // Phases lean towards filling, draining or churning the table.
            if (n % PHASE_ITEMS == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_share = 85;
                    1: insert_share = 15;
                    default: insert_share = 50;
                endcase
            end
            if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, 7)] = $urandom;
            r = $urandom_range(0, 99);
            if (r < 5) begin
                op = OP_SPARE;
            end else if (r < 25) begin
                op = OP_READ;
            end else if ($urandom_range(0, 99) < insert_share) begin
                op = OP_INSERT;
            end else begin
                op = OP_DELETE;
            end
            issue(op, pick_key(), IDX_W'($urandom_range(0, TABLE_DEPTH - 1)));
            if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
                pause($urandom_range(1, 18));
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sorted_key_table.f @@
rtl/skt_pkg.sv
rtl/skt_ram.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table.sv
bench/key_table_checker.sv
bench/testbench.sv
